[hw/rtl/impt_pkg.sv]
// Shared types and codes for the indexed max-priority table unit.
// No dependencies; used by impt_ctrl, impt_dpath and the top level.
`default_nettype none

package impt_pkg;

   // Operation codes carried on req_operation
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_RAISE  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // Fixed port field widths
   localparam int OP_BITS    = 2;
   localparam int ID_BITS    = 6;
   localparam int VALUE_BITS = 16;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear_wr;   // write an empty word at the sweep counter
      logic insert_wr;  // write the request beat as a fresh entry
      logic remove_wr;  // write an empty word at the request id
      logic raise_rd;   // capture request, read entry at request id
      logic raise_wr;   // write back the saturated level
      logic scan_init;  // zero the sweep counter and clear the found flag
      logic scan_rd;    // read at the sweep counter and advance it
      logic rsp_load;   // move the best-so-far into the output register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic id_ok;      // request id lies inside the table
      logic cnt_last;   // sweep counter sits on the last entry
      logic rsp_free;   // output register can take a beat this cycle
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/impt_ctrl.sv]
// Controller state machine for the indexed max-priority table unit.
// Depends on impt_pkg; drives impt_dpath through cmd_type, reads status_type.
`default_nettype none

module impt_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [impt_pkg::OP_BITS-1:0]        req_operation,
   input  wire impt_pkg::status_type                status,
   output impt_pkg::cmd_type                        cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RAISE = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  impt_pkg::OP_INSERT: cmd.insert_wr = status.id_ok;
                  impt_pkg::OP_REMOVE: cmd.remove_wr = status.id_ok;
                  impt_pkg::OP_RAISE: begin
                     if (status.id_ok) begin
                        cmd.raise_rd = 1'b1;
                        state_in     = S_RAISE;
                     end
                  end
                  impt_pkg::OP_QUERY: begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               endcase
            end
         end
         S_RAISE: begin
            cmd.raise_wr = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Never overwrite a beat that the output still holds
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded while output register busy");

   // One memory write source at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.insert_wr, cmd.remove_wr, cmd.raise_wr}))
      else $error("conflicting memory writes");

   // Raise write-back uses the read issued the cycle before
   assert property (@(posedge clock) disable iff (reset)
      cmd.raise_wr |-> $past(cmd.raise_rd))
      else $error("raise write without preceding read");

   // A sweep read continues a sweep that was started
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> $past(cmd.scan_init || cmd.scan_rd))
      else $error("scan read outside a sweep");
`endif

endmodule

`default_nettype wire

[hw/rtl/impt_dpath.sv]
// Datapath for the indexed max-priority table unit: entry memory, sweep
// counter, arrival counter, best-so-far compare and output register.
// Depends on impt_pkg; commanded by impt_ctrl.
`default_nettype none

module impt_dpath #(
   parameter int ENTRIES      = 64,
   parameter int LEVEL_BITS   = 16,
   parameter int ARRIVAL_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [impt_pkg::ID_BITS-1:0]          req_entry_id,
   input  wire logic [impt_pkg::VALUE_BITS-1:0]       req_level_value,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic                                       rsp_is_empty,
   output logic [impt_pkg::ID_BITS-1:0]               rsp_top_entry,
   output logic [impt_pkg::VALUE_BITS-1:0]            rsp_top_level,
   input  wire impt_pkg::cmd_type                     cmd,
   output impt_pkg::status_type                       status
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int IDE_W  = IDX_W + impt_pkg::ID_BITS + 1;
   localparam int WORD_W = 1 + LEVEL_BITS + ARRIVAL_BITS;

   // Entry memory: {occupied, level, arrival}
   logic [WORD_W-1:0] mem [ENTRIES];

   logic [WORD_W-1:0]       rd_data_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    scan_pend_ff;
   logic [IDX_W-1:0]        cnt_ff;
   logic [ARRIVAL_BITS-1:0] next_arr_ff;
   logic [IDX_W-1:0]        cap_id_ff;
   logic [LEVEL_BITS-1:0]   cap_val_ff;
   logic                    found_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   logic [LEVEL_BITS-1:0]   best_lvl_ff;
   logic [ARRIVAL_BITS-1:0] best_arr_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_empty_ff;
   logic [impt_pkg::ID_BITS-1:0]    rsp_entry_ff;
   logic [impt_pkg::VALUE_BITS-1:0] rsp_level_ff;

   logic [IDE_W-1:0]                 id_ext;
   logic [IDX_W-1:0]                 id_idx;
   logic [LEVEL_BITS+impt_pkg::VALUE_BITS-1:0] val_ext;
   logic [LEVEL_BITS-1:0]            req_val;
   logic                             rd_occ;
   logic [LEVEL_BITS-1:0]            rd_lvl;
   logic [ARRIVAL_BITS-1:0]          rd_arr;
   logic [LEVEL_BITS:0]              raise_sum;
   logic [LEVEL_BITS-1:0]            raise_lvl;
   logic                             better;
   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [WORD_W-1:0]                wr_data;
   logic [IDX_W-1:0]                 rd_addr;
   logic [IDX_W+impt_pkg::ID_BITS-1:0]         best_idx_ext;
   logic [LEVEL_BITS+impt_pkg::VALUE_BITS-1:0] best_lvl_ext;

   // Decode the request id and value
   assign id_ext  = {{(IDX_W + 1){1'b0}}, req_entry_id};
   assign id_idx  = id_ext[IDX_W-1:0];
   assign val_ext = {{LEVEL_BITS{1'b0}}, req_level_value};
   assign req_val = val_ext[LEVEL_BITS-1:0];

   assign status.id_ok    = (id_ext < IDE_W'(ENTRIES));
   assign status.cnt_last = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // Split the registered read word
   assign rd_occ = rd_data_ff[WORD_W-1];
   assign rd_lvl = rd_data_ff[ARRIVAL_BITS +: LEVEL_BITS];
   assign rd_arr = rd_data_ff[ARRIVAL_BITS-1:0];

   // Saturating raise
   assign raise_sum = {1'b0, rd_lvl} + {1'b0, cap_val_ff};
   assign raise_lvl = raise_sum[LEVEL_BITS] ? {LEVEL_BITS{1'b1}} : raise_sum[LEVEL_BITS-1:0];

   // Higher level wins, then earlier arrival; ties keep the lower index
   assign better = rd_occ && (!found_ff || (rd_lvl > best_lvl_ff) ||
                  ((rd_lvl == best_lvl_ff) && (rd_arr < best_arr_ff)));

   // Select the write port source
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = id_idx;
      wr_data = '0;
      priority if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
      end else if (cmd.insert_wr) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, req_val, next_arr_ff};
      end else if (cmd.remove_wr) begin
         wr_en   = 1'b1;
      end else if (cmd.raise_wr) begin
         wr_en   = rd_occ;
         wr_addr = cap_id_ff;
         wr_data = {1'b1, raise_lvl, rd_arr};
      end
   end

   assign rd_addr = cmd.raise_rd ? id_idx : cnt_ff;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_idx_ff  <= cnt_ff;
   end

   // Control registers: sweep counter, arrival counter, flags
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         next_arr_ff  <= '0;
         scan_pend_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_pend_ff <= cmd.scan_rd;
         if (cmd.scan_init) begin
            cnt_ff <= '0;
         end else if (cmd.clear_wr || cmd.scan_rd) begin
            cnt_ff <= status.cnt_last ? '0 : cnt_ff + IDX_W'(1);
         end
         if (cmd.insert_wr) begin
            next_arr_ff <= next_arr_ff + ARRIVAL_BITS'(1);
         end
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (scan_pend_ff && better) begin
            found_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign best_idx_ext = {{impt_pkg::ID_BITS{1'b0}}, best_idx_ff};
   assign best_lvl_ext = {{impt_pkg::VALUE_BITS{1'b0}}, best_lvl_ff};

   // Payload registers: raise capture, best-so-far, output beat
   always_ff @(posedge clock) begin
      if (cmd.raise_rd) begin
         cap_id_ff  <= id_idx;
         cap_val_ff <= req_val;
      end
      if (scan_pend_ff && better) begin
         best_idx_ff <= rd_idx_ff;
         best_lvl_ff <= rd_lvl;
         best_arr_ff <= rd_arr;
      end
      if (cmd.rsp_load) begin
         rsp_empty_ff <= !found_ff;
         rsp_entry_ff <= found_ff ? best_idx_ext[impt_pkg::ID_BITS-1:0] : '0;
         rsp_level_ff <= found_ff ? best_lvl_ext[impt_pkg::VALUE_BITS-1:0] : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_top_entry = rsp_entry_ff;
   assign rsp_top_level = rsp_level_ff;

endmodule

`default_nettype wire

[hw/rtl/indexed_max_priority_table_unit.sv]
// Indexed max-priority table unit. Insert and remove write on accept; raise
// reads the entry and then writes it back. A query sweeps the entry memory
// one entry a cycle; rsp_valid rises in the same cycle that req_ready returns.
// One item is in work at a time; a held result beat stalls the next query.
// After reset a clearing pass empties the table; req_ready stays low until
// it ends. Depends on impt_pkg, impt_ctrl and impt_dpath.
`default_nettype none

module indexed_max_priority_table_unit #(
   parameter int ENTRIES      = 64,
   parameter int LEVEL_BITS   = 16,
   parameter int ARRIVAL_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [impt_pkg::OP_BITS-1:0]          req_operation,
   input  wire logic [impt_pkg::ID_BITS-1:0]          req_entry_id,
   input  wire logic [impt_pkg::VALUE_BITS-1:0]       req_level_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_is_empty,
   output logic [impt_pkg::ID_BITS-1:0]               rsp_top_entry,
   output logic [impt_pkg::VALUE_BITS-1:0]            rsp_top_level
);

   impt_pkg::cmd_type    cmd;
   impt_pkg::status_type status;

   impt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   impt_dpath #(
      .ENTRIES      (ENTRIES),
      .LEVEL_BITS   (LEVEL_BITS),
      .ARRIVAL_BITS (ARRIVAL_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_entry_id    (req_entry_id),
      .req_level_value (req_level_value),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_top_entry   (rsp_top_entry),
      .rsp_top_level   (rsp_top_level),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

[tb/indexed_max_priority_table_unit_tb.sv]
// Self-checking testbench for the indexed max-priority table unit: a table
// model predicts every query answer and checks the result beats in order.
// Depends on impt_pkg and indexed_max_priority_table_unit.
`timescale 1ns / 1ps

localparam int TABLE_SLOTS = 64;

typedef struct packed {
   logic                              is_empty;
   logic [impt_pkg::ID_BITS-1:0]      top_entry;
   logic [impt_pkg::VALUE_BITS-1:0]   top_level;
} top_answer_type;

// Table state plus the queue of query answers still owed by the block
class level_table;
   bit                                occupied [TABLE_SLOTS];
   logic [impt_pkg::VALUE_BITS-1:0]   level [TABLE_SLOTS];
   logic [31:0]                       stamp [TABLE_SLOTS];
   logic [31:0]                       next_stamp;
   top_answer_type                    answers_due [$];
   int                                mismatches;

   function new();
      foreach (occupied[k]) occupied[k] = 1'b0;
      next_stamp = '0;
      mismatches = 0;
   endfunction

   // Scan for the highest level; earliest stamp, then lowest index, wins ties
   function top_answer_type highest();
      top_answer_type best;
      bit             found;
      best  = '0;
      found = 1'b0;
      best.is_empty = 1'b1;
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         if (occupied[k]) begin
            if (!found || level[k] > best.top_level ||
                (level[k] == best.top_level && stamp[k] < stamp[best.top_entry])) begin
               best.is_empty  = 1'b0;
               best.top_entry = impt_pkg::ID_BITS'(k);
               best.top_level = level[k];
               found = 1'b1;
            end
         end
      end
      return best;
   endfunction

   // Apply one accepted request beat
   function void note_request(logic [1:0] op, logic [5:0] id, logic [15:0] val);
      logic [16:0] sum;
      case (op)
         impt_pkg::OP_INSERT: begin
            occupied[id] = 1'b1;
            level[id]    = val;
            stamp[id]    = next_stamp;
            next_stamp   = next_stamp + 1;
         end
         impt_pkg::OP_RAISE: begin
            if (occupied[id]) begin
               sum       = {1'b0, level[id]} + {1'b0, val};
               level[id] = sum[16] ? '1 : sum[15:0];
            end
         end
         impt_pkg::OP_REMOVE: begin
            occupied[id] = 1'b0;
         end
         impt_pkg::OP_QUERY: begin
            answers_due.push_back(highest());
         end
      endcase
   endfunction

   task report_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Compare one result beat against the oldest owed answer
   task check_top(top_answer_type got);
      top_answer_type want;
      if (answers_due.size() == 0) begin
         report_mismatch("result beat with no query outstanding");
      end else begin
         want = answers_due.pop_front();
         if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, want %0b", got.is_empty, want.is_empty));
         if (got.top_entry !== want.top_entry)
            report_mismatch($sformatf("top_entry %0d, want %0d",
                                      got.top_entry, want.top_entry));
         if (got.top_level !== want.top_level)
            report_mismatch($sformatf("top_level %0d, want %0d",
                                      got.top_level, want.top_level));
      end
   endtask

   function int pending();
      return answers_due.size();
   endfunction
endclass

module indexed_max_priority_table_unit_tb;

   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT_NS    = 2_000_000;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [impt_pkg::OP_BITS-1:0]      req_operation;
   logic [impt_pkg::ID_BITS-1:0]      req_entry_id;
   logic [impt_pkg::VALUE_BITS-1:0]   req_level_value;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_is_empty;
   logic [impt_pkg::ID_BITS-1:0]      rsp_top_entry;
   logic [impt_pkg::VALUE_BITS-1:0]   rsp_top_level;

   top_answer_type                    rsp_beat;
   level_table                        table_model;
   bit                                calm;
   int                                holdoffs_asked;
   int                                holdoffs_done;

   indexed_max_priority_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_entry_id    (req_entry_id),
      .req_level_value (req_level_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_top_entry   (rsp_top_entry),
      .rsp_top_level   (rsp_top_level)
   );

   assign rsp_beat = {rsp_is_empty, rsp_top_entry, rsp_top_level};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watch both channels at the rising edge; note requests before checking
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            table_model.note_request(req_operation, req_entry_id, req_level_value);
         if (rsp_valid && rsp_ready)
            table_model.check_top(rsp_beat);
      end
   end

   // Offer one request beat and hold it until accepted
   task automatic send_request(logic [1:0] op, logic [5:0] id, logic [15:0] val);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_id    <= id;
      req_level_value <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed answer has arrived
   task automatic drain_answers();
      req_valid <= 1'b0;
      @(negedge clock);
      while (table_model.pending() != 0) @(negedge clock);
   endtask

   // Extremes, ties and each special case
   task automatic run_directed();
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);       // empty table
      send_request(impt_pkg::OP_INSERT, 6'd0,  16'd0);
      send_request(impt_pkg::OP_INSERT, 6'd63, 16'hFFFF);
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
      send_request(impt_pkg::OP_RAISE,  6'd63, 16'd1);       // saturate
      send_request(impt_pkg::OP_RAISE,  6'd0,  16'hFFFF);    // zero to max
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
      send_request(impt_pkg::OP_RAISE,  6'd5,  16'd100);     // absent, ignored
      send_request(impt_pkg::OP_REMOVE, 6'd10, 16'hFFFF);    // absent, no effect
      send_request(impt_pkg::OP_INSERT, 6'd5,  16'hFFFF);
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
      send_request(impt_pkg::OP_INSERT, 6'd0,  16'hFFFF);    // overwrite, new stamp
      send_request(impt_pkg::OP_INSERT, 6'd63, 16'hFFFF);
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
      send_request(impt_pkg::OP_REMOVE, 6'd5,  16'd0);
      send_request(impt_pkg::OP_REMOVE, 6'd0,  16'd0);
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
      send_request(impt_pkg::OP_REMOVE, 6'd63, 16'd0);
      send_request(impt_pkg::OP_QUERY,  6'd63, 16'hFFFF);    // empty again
      send_request(impt_pkg::OP_INSERT, 6'd20, 16'd1000);
      send_request(impt_pkg::OP_INSERT, 6'd30, 16'd999);
      send_request(impt_pkg::OP_RAISE,  6'd30, 16'd1);       // tie, earlier wins
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
      send_request(impt_pkg::OP_RAISE,  6'd30, 16'd0);
      send_request(impt_pkg::OP_QUERY,  6'd0,  16'd0);
   endtask

   // Random traffic: phases of low levels for ties, full range otherwise
   task automatic run_random(int total);
      logic [1:0]      op;
      logic [5:0]      id;
      logic [15:0]     val;
      int              pick;
      int              burst;
      bit              low_levels;
      top_answer_type  top;
      burst = 0;
      for (int i = 0; i < total; i++) begin
         if (i == 200) calm = 1'b1;
         if (i == 350) calm = 1'b0;
         if (i == 450) begin
            holdoffs_asked++;
            burst = 10;
         end
         if (i == 600) drain_answers();
         low_levels = ((i / 100) % 2) == 1;
         pick = $urandom_range(99);
         id   = ($urandom_range(1) == 1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
         if (burst > 0) begin
            op = impt_pkg::OP_QUERY;
            burst--;
         end else if (pick < 30) op = impt_pkg::OP_INSERT;
         else if (pick < 50) op = impt_pkg::OP_RAISE;
         else if (pick < 65) op = impt_pkg::OP_REMOVE;
         else op = impt_pkg::OP_QUERY;
         pick = $urandom_range(99);
         case (op)
            impt_pkg::OP_INSERT: begin
               if (low_levels) val = 16'($urandom_range(3));
               else if (pick < 20) val = 16'(16'hFFF0 + $urandom_range(15));
               else val = 16'($urandom_range(16'hFFFF));
            end
            impt_pkg::OP_RAISE: begin
               if (low_levels) val = 16'($urandom_range(1));
               else if (pick < 25) val = 16'(16'hC000 + $urandom_range(16'h3FFF));
               else val = 16'($urandom_range(16'hFFFF));
            end
            impt_pkg::OP_REMOVE: begin
               val = 16'($urandom_range(16'hFFFF));
               top = table_model.highest();
               // often take out the current winner to expose the runner-up
               if (!top.is_empty && pick < 50) id = top.top_entry;
            end
            default: begin
               val = 16'($urandom_range(16'hFFFF));
            end
         endcase
         send_request(op, id, val);
      end
   endtask

   // Result side: random stalls, a calm stretch and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_asked > holdoffs_done) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
            holdoffs_done++;
         end
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("indexed_max_priority_table_unit test failed");
      $finish;
   end

   // Main sequence
   initial begin
      table_model     = new();
      calm            = 1'b0;
      holdoffs_asked  = 0;
      holdoffs_done   = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = impt_pkg::OP_INSERT;
      req_entry_id    = '0;
      req_level_value = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      drain_answers();
      run_random(800);
      req_valid <= 1'b0;
      while (table_model.pending() != 0) @(posedge clock);
      repeat (TABLE_SLOTS + 8) @(posedge clock);
      if (table_model.mismatches == 0)
         $display("indexed_max_priority_table_unit test passed");
      else
         $display("indexed_max_priority_table_unit test failed");
      $finish;
   end

endmodule

[files.f]
hw/rtl/impt_pkg.sv
hw/rtl/impt_ctrl.sv
hw/rtl/impt_dpath.sv
hw/rtl/indexed_max_priority_table_unit.sv
tb/indexed_max_priority_table_unit_tb.sv
